### hw/rtl/mcpi_pkg.sv
// ----------------------------------------------------------------------------
// mcpi_pkg
// Shared types, constants and helpers for the maglev cascaded PI controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcpi_pkg;

  localparam int FRAME_LENGTH = 6;
  localparam int SAMPLE_MAX   = 1023;
  localparam int SAMPLE_W     = 16;
  localparam int SIG_W        = 32;
  localparam int GAIN_W       = 24;
  localparam int MUL_SIG_W    = 34;
  localparam int MUL_PROD_W   = GAIN_W + MUL_SIG_W;
  localparam int MUL_RES_W    = MUL_PROD_W - 12;
  localparam int DIV_NUM_W    = 40;
  localparam int DIV_DEN_W    = 24;
  localparam int WIDE_W       = 48;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam logic [7:0] PWM_FULL    = 8'd254;

  // position error scale: 16384 / 5115, current scale: 1638400 / 11253
  localparam logic [DIV_DEN_W-1:0] POS_DEN = DIV_DEN_W'(2 * 5115);
  localparam logic [DIV_DEN_W-1:0] CUR_DEN = DIV_DEN_W'(2 * 11253);
  localparam logic [DIV_DEN_W-1:0] BACK_DEN = DIV_DEN_W'(20);

  localparam logic [9:0]        RST_SETPOINT = 10'd102;
  localparam logic [GAIN_W-1:0] RST_OKP  = 24'd409600;
  localparam logic [GAIN_W-1:0] RST_OKI  = 24'd2048;
  localparam logic [GAIN_W-1:0] RST_OKD  = 24'd614400;
  localparam logic [GAIN_W-1:0] RST_IKP  = 24'd49152;
  localparam logic [GAIN_W-1:0] RST_IKI  = 24'd122880;
  localparam logic [GAIN_W-1:0] RST_ILIM = 24'd54198;
  localparam logic [GAIN_W-1:0] RST_VLIM = 24'd646185;

  typedef enum logic [2:0] {
    REG_SETPOINT = 3'd0,
    REG_OKP      = 3'd1,
    REG_OKI      = 3'd2,
    REG_OKD      = 3'd3,
    REG_IKP      = 3'd4,
    REG_IKI      = 3'd5,
    REG_ILIM     = 3'd6,
    REG_VLIM     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                done;
    logic                in_range;
    logic [SAMPLE_W-1:0] pos;
    logic [SAMPLE_W-1:0] cur;
  } frame_t;

  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - WIDE_W'(signed'(2'sd1));
    if (v > hi) return hi[SIG_W-1:0];
    else if (v < lo) return lo[SIG_W-1:0];
    else return v[SIG_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/maglev_cascaded_pi_controller.sv
// Per frame: position and current divides, outer P and D multiplies, outer
//   integrator, inner P, inner integrator (a back-off divide replaces the multiply
//   of an out-of-range integrator), PWM scale divide if the voltage limit is nonzero.
// Throughput: one word per cycle while hunting or filling a frame; input stalls while
//   a frame is computed, and the last word of a frame waits for the pending PWM word.
// Reset (synchronous, active low): registers to defaults, integrators, frame cleared.
// ----------------------------------------------------------------------------
// maglev_cascaded_pi_controller
// Serial frame decoder with cascaded position PID / current PI and PWM scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module maglev_cascaded_pi_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // byte stream in
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  // PWM word out
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_pwm_byte,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcpi_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mcpi_pkg::DATA_W-1:0]   pwdata,
  output logic [mcpi_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import mcpi_pkg::*;

  // one-hot sequencer: each wait state waits on the shared multiplier or divider
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DE   = 11'b000_0000_0010,  // position error divide
    S_DC   = 11'b000_0000_0100,  // current scale divide
    S_MP   = 11'b000_0000_1000,  // outer P
    S_MD   = 11'b000_0001_0000,  // outer D
    S_OI   = 11'b000_0010_0000,  // outer integrator (mul or back-off divide)
    S_DEM  = 11'b000_0100_0000,  // demand clamp, inner error
    S_MPI  = 11'b000_1000_0000,  // inner P
    S_II   = 11'b001_0000_0000,  // inner integrator
    S_V    = 11'b010_0000_0000,  // voltage clamp
    S_DV   = 11'b100_0000_0000   // PWM scale divide
  } state_t;

  state_t state_r, state_nxt;

  // ---------------- configuration registers ----------------
  logic [9:0]        setpoint_r;
  logic [GAIN_W-1:0] okp_r, oki_r, okd_r, ikp_r, iki_r, ilim_r, vlim_r;
  logic              cfg_wr;
  reg_idx_t          widx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= RST_SETPOINT;
      okp_r      <= RST_OKP;
      oki_r      <= RST_OKI;
      okd_r      <= RST_OKD;
      ikp_r      <= RST_IKP;
      iki_r      <= RST_IKI;
      ilim_r     <= RST_ILIM;
      vlim_r     <= RST_VLIM;
    end else if (cfg_wr) begin
      case (widx)
        REG_SETPOINT: setpoint_r <= pwdata[9:0];
        REG_OKP:      okp_r      <= pwdata[GAIN_W-1:0];
        REG_OKI:      oki_r      <= pwdata[GAIN_W-1:0];
        REG_OKD:      okd_r      <= pwdata[GAIN_W-1:0];
        REG_IKP:      ikp_r      <= pwdata[GAIN_W-1:0];
        REG_IKI:      iki_r      <= pwdata[GAIN_W-1:0];
        REG_ILIM:     ilim_r     <= pwdata[GAIN_W-1:0];
        REG_VLIM:     vlim_r     <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_SETPOINT: prdata = DATA_W'(setpoint_r);
      REG_OKP:      prdata = DATA_W'(okp_r);
      REG_OKI:      prdata = DATA_W'(oki_r);
      REG_OKD:      prdata = DATA_W'(okd_r);
      REG_IKP:      prdata = DATA_W'(ikp_r);
      REG_IKI:      prdata = DATA_W'(iki_r);
      REG_ILIM:     prdata = DATA_W'(ilim_r);
      REG_VLIM:     prdata = DATA_W'(vlim_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- frame assembly ----------------
  frame_t frm;
  logic   last_slot;
  logic   in_take;
  logic   out_valid_r;
  logic [7:0] out_pwm_r;

  // the last word of a frame waits while a PWM word is still pending
  assign in_stall = (state_r != S_IDLE) | frm.done | (out_valid_r & last_slot);
  assign in_take  = in_valid & ~in_stall;

  mcpi_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (in_take),
    .byte_in   (in_rx_byte),
    .last_slot (last_slot),
    .frm       (frm)
  );

  // ---------------- shared serial units ----------------
  logic                        mul_go, mul_done;
  logic [GAIN_W-1:0]           mul_gain;
  logic signed [MUL_SIG_W-1:0] mul_sig;
  logic signed [MUL_RES_W-1:0] mul_res;
  logic                        div_go, div_done;
  logic [DIV_NUM_W-1:0]        div_num, div_quo;
  logic [DIV_DEN_W-1:0]        div_den;

  mcpi_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .gain(mul_gain), .sig(mul_sig),
    .done(mul_done), .res(mul_res)
  );

  mcpi_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // ---------------- controller state and datapath ----------------
  logic signed [SIG_W-1:0] ef_r, ie_r, prop_r, deriv_r, prev_r, oi_r, ii_r;
  logic signed [SIG_W-1:0] ei_r, propi_r;
  logic                    ef_neg_r, oob_r, oob_hi_r;

  logic signed [DIV_NUM_W-1:0] diff, ef_n, ef_num;
  logic signed [DIV_NUM_W-1:0] ilim_s, vlim_s, oi_s, ii_s;
  logic [DIV_NUM_W-1:0]        ie_num, ob_num, ib_num;
  logic signed [DIV_NUM_W-1:0] dem, dem_c1, dem_c, v, v1, v2;
  logic signed [WIDE_W-1:0]    ei_full;
  logic signed [SIG_W-1:0]     ei_c;
  logic signed [DIV_NUM_W-1:0] q_s;
  logic                        oi_ok, ii_ok;

  assign ilim_s = DIV_NUM_W'(ilim_r);
  assign vlim_s = DIV_NUM_W'(vlim_r);
  assign oi_s   = DIV_NUM_W'(oi_r);
  assign ii_s   = DIV_NUM_W'(ii_r);
  assign q_s    = signed'(div_quo);

  // error = floor((diff*32768 + 5115) / 10230); negative side via ceil trick
  assign diff   = DIV_NUM_W'(setpoint_r) - DIV_NUM_W'(frm.pos);
  assign ef_n   = (diff <<< 15) + DIV_NUM_W'(5115);
  assign ef_num = (ef_n < 0) ? (-ef_n + DIV_NUM_W'(POS_DEN) - DIV_NUM_W'(1)) : ef_n;
  assign ie_num = DIV_NUM_W'(frm.cur) * DIV_NUM_W'(3276800) + DIV_NUM_W'(11253);

  // back-off level 0.95 * limit
  assign ob_num = DIV_NUM_W'(ilim_r) * DIV_NUM_W'(19) + DIV_NUM_W'(10);
  assign ib_num = DIV_NUM_W'(vlim_r) * DIV_NUM_W'(19) + DIV_NUM_W'(10);

  assign oi_ok = (oi_s > -ilim_s) && (oi_s < ilim_s);
  assign ii_ok = (ii_s > -vlim_s) && (ii_s < vlim_s);

  // demand clamp to [-ilim, 0] and inner error
  assign dem     = DIV_NUM_W'(prop_r) + oi_s + DIV_NUM_W'(deriv_r);
  assign dem_c1  = (dem > 0) ? '0 : dem;
  assign dem_c   = (dem_c1 <= -ilim_s) ? -ilim_s : dem_c1;
  assign ei_full = WIDE_W'(-dem_c) - WIDE_W'(ie_r);
  assign ei_c    = sat32(ei_full);

  // voltage clamp to [0, vlim]
  assign v  = DIV_NUM_W'(propi_r) + ii_s;
  assign v1 = (v >= vlim_s) ? vlim_s : v;
  assign v2 = (v1 <= 0) ? '0 : v1;

  always_comb begin
    state_nxt = state_r;
    mul_go    = 1'b0;
    mul_gain  = okp_r;
    mul_sig   = MUL_SIG_W'(ef_r);
    div_go    = 1'b0;
    div_num   = ef_num;
    div_den   = POS_DEN;
    case (state_r)
      S_IDLE: if (frm.done && frm.in_range) begin
        div_go    = 1'b1;
        state_nxt = S_DE;
      end
      S_DE: if (div_done) begin
        div_go    = 1'b1;
        div_num   = ie_num;
        div_den   = CUR_DEN;
        state_nxt = S_DC;
      end
      S_DC: if (div_done) begin
        mul_go    = 1'b1;
        state_nxt = S_MP;
      end
      S_MP: if (mul_done) begin
        mul_go    = 1'b1;
        mul_gain  = okd_r;
        mul_sig   = MUL_SIG_W'(ef_r) - MUL_SIG_W'(prev_r);
        state_nxt = S_MD;
      end
      S_MD: if (mul_done) begin
        if (oi_ok) begin
          mul_go   = 1'b1;
          mul_gain = oki_r;
        end else begin
          div_go  = 1'b1;
          div_num = ob_num;
          div_den = BACK_DEN;
        end
        state_nxt = S_OI;
      end
      S_OI: if (mul_done || div_done) state_nxt = S_DEM;
      S_DEM: begin
        mul_go    = 1'b1;
        mul_gain  = ikp_r;
        mul_sig   = MUL_SIG_W'(ei_c);
        state_nxt = S_MPI;
      end
      S_MPI: if (mul_done) begin
        if (ii_ok) begin
          mul_go   = 1'b1;
          mul_gain = iki_r;
          mul_sig  = MUL_SIG_W'(ei_r);
        end else begin
          div_go  = 1'b1;
          div_num = ib_num;
          div_den = BACK_DEN;
        end
        state_nxt = S_II;
      end
      S_II: if (mul_done || div_done) state_nxt = S_V;
      S_V: begin
        if (vlim_r != '0) begin
          div_go    = 1'b1;
          div_num   = DIV_NUM_W'(v2[GAIN_W-1:0]) * DIV_NUM_W'(PWM_FULL);
          div_den   = vlim_r;
          state_nxt = S_DV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DV: if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // controller state (reset to zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      oi_r   <= '0;
      ii_r   <= '0;
    end else begin
      if (state_r == S_MD && mul_done) prev_r <= ef_r;
      if (state_r == S_OI) begin
        if (div_done) oi_r <= oob_hi_r ? div_quo[SIG_W-1:0] : -div_quo[SIG_W-1:0];
        else if (mul_done) oi_r <= sat32(WIDE_W'(oi_r) + WIDE_W'(mul_res));
      end
      if (state_r == S_II) begin
        if (div_done) ii_r <= oob_hi_r ? div_quo[SIG_W-1:0] : -div_quo[SIG_W-1:0];
        else if (mul_done) ii_r <= sat32(WIDE_W'(ii_r) + WIDE_W'(mul_res));
      end
    end
  end

  // per-frame working values
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: ef_neg_r <= (ef_n < 0);
      S_DE:   if (div_done) ef_r <= ef_neg_r ? -q_s[SIG_W-1:0] : q_s[SIG_W-1:0];
      S_DC:   if (div_done) ie_r <= q_s[SIG_W-1:0];
      S_MP:   if (mul_done) prop_r <= sat32(WIDE_W'(mul_res));
      S_MD:   if (mul_done) begin
        deriv_r  <= sat32(WIDE_W'(mul_res));
        oob_r    <= ~oi_ok;
        oob_hi_r <= (oi_s >= ilim_s);
      end
      S_DEM:  ei_r <= ei_c;
      S_MPI:  if (mul_done) begin
        propi_r  <= sat32(WIDE_W'(mul_res));
        oob_r    <= ~ii_ok;
        oob_hi_r <= (ii_s >= vlim_s);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_V && vlim_r == '0) || (state_r == S_DV && div_done))
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_V && vlim_r == '0) out_pwm_r <= '0;
    else if (state_r == S_DV && div_done)
      out_pwm_r <= (div_quo > DIV_NUM_W'(PWM_FULL)) ? PWM_FULL : div_quo[7:0];
  end

  assign out_valid    = out_valid_r;
  assign out_pwm_byte = out_pwm_r;

  // ---------------- assertions ----------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DV || $past(state_r) == S_V))
    else $error("PWM word raised outside the output step");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (state_r == S_IDLE && !frm.done))
    else $error("word taken while the controller runs");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (frm.done && frm.in_range && state_r == S_IDLE) |-> !out_valid_r)
    else $error("frame completed with a PWM word still pending");

  a_oob_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OI && oob_r) |-> !mul_done)
    else $error("multiplier finished during integrator back-off");

endmodule

`default_nettype wire

### hw/rtl/mcpi_frame.sv
// ----------------------------------------------------------------------------
// mcpi_frame
// Header hunt and 6-word frame assembly; flags samples out of range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpi_frame (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_take,
  input  wire logic [7:0]    byte_in,
  output logic               last_slot,
  output mcpi_pkg::frame_t   frm
);
  import mcpi_pkg::*;

  localparam int POS_W = $clog2(FRAME_LENGTH);

  logic [POS_W-1:0] fpos_r;
  logic [7:0]       fbyte_r [4];
  logic             done_r;

  assign last_slot = (fpos_r == POS_W'(FRAME_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpos_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= byte_take & last_slot;
      if (byte_take) begin
        if (fpos_r == '0) begin
          if (byte_in == HEADER_BYTE) fpos_r <= POS_W'(1);
        end else if (last_slot) begin
          fpos_r <= '0;
        end else begin
          fpos_r <= fpos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && fpos_r != '0 && fpos_r <= POS_W'(4))
      fbyte_r[2'(fpos_r - POS_W'(1))] <= byte_in;
  end

  always_comb begin
    frm.done     = done_r;
    frm.pos      = {fbyte_r[0], fbyte_r[1]};
    frm.cur      = {fbyte_r[2], fbyte_r[3]};
    frm.in_range = (frm.pos <= SAMPLE_W'(SAMPLE_MAX)) && (frm.cur <= SAMPLE_W'(SAMPLE_MAX));
  end

endmodule

`default_nettype wire

### hw/rtl/mcpi_mul.sv
// ----------------------------------------------------------------------------
// mcpi_mul
// Bit-serial gain multiplier, one gain bit per cycle, Q12.12 rescale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpi_mul (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 go,
  input  wire logic [mcpi_pkg::GAIN_W-1:0]          gain,
  input  wire logic signed [mcpi_pkg::MUL_SIG_W-1:0] sig,
  output logic                                      done,
  output logic signed [mcpi_pkg::MUL_RES_W-1:0]     res
);
  import mcpi_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [GAIN_W-1:0]            gain_sr_r;
  logic signed [MUL_PROD_W-1:0] mcand_r;
  logic signed [MUL_PROD_W-1:0] acc_r;
  logic signed [MUL_PROD_W-1:0] rnd;
  logic [CNT_W-1:0]             cnt_r;
  logic                         done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && (cnt_r == CNT_W'(1));
      if (go) begin
        cnt_r <= CNT_W'(GAIN_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      gain_sr_r <= gain;
      mcand_r   <= MUL_PROD_W'(sig);
      acc_r     <= '0;
    end else if (cnt_r != '0) begin
      if (gain_sr_r[0]) acc_r <= acc_r + mcand_r;
      gain_sr_r <= gain_sr_r >> 1;
      mcand_r   <= mcand_r <<< 1;
    end
  end

  assign rnd  = acc_r + MUL_PROD_W'(2048);
  assign res  = rnd[MUL_PROD_W-1:12];
  assign done = done_r;

endmodule

`default_nettype wire

### hw/rtl/mcpi_div.sv
// ----------------------------------------------------------------------------
// mcpi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpi_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             go,
  input  wire logic [mcpi_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [mcpi_pkg::DIV_DEN_W-1:0]   den,
  output logic                                  done,
  output logic [mcpi_pkg::DIV_NUM_W-1:0]        quo
);
  import mcpi_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] sr_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;

  assign trial = {rem_r, sr_r[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !go && (cnt_r == CNT_W'(1));
      if (go) begin
        cnt_r <= CNT_W'(DIV_NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sr_r  <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      sr_r  <= {sr_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign quo  = sr_r;
  assign done = done_r;

endmodule

`default_nettype wire
